>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion under the active-low reset
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion without a reset qualifier
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mmuq_pkg.sv
// ---------------------------------------------------------------------------
// mmuq_pkg: shared types and constants
// Payload structs, level limits, function codes and the front/back enums.
// ---------------------------------------------------------------------------
package mmuq_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned LevelW  = 8;
  localparam logic [CfgW-1:0] LevelsReset = 9'd8;
  localparam logic [CfgW-1:0] MaxLevels   = 9'd256;

  localparam logic FuncObserve  = 1'b0;
  localparam logic FuncQuantize = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [SampleW-1:0] sample;
    logic               start_req;
  } in_word_t;

  typedef struct packed {
    logic [LevelW-1:0]          level;
    logic signed [SampleW-1:0]  recon_value;
    logic                       out_of_range;
    logic                       flat;
  } out_word_t;

  // Classification done in the front part
  typedef enum logic [1:0] {
    CLS_FLAT  = 2'd0,
    CLS_BELOW = 2'd1,
    CLS_ABOVE = 2'd2,
    CLS_INNER = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV1 = 2'd1,
    BK_DIV2 = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_e;

endpackage

>>> hdl/min_max_uniform_quantizer_core.sv
// ---------------------------------------------------------------------------
// min_max_uniform_quantizer_core: min/max uniform quantizer
// Tracks a signed sample range and maps samples onto evenly spaced levels.
// ---------------------------------------------------------------------------
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------
// input    | in_valid_i / in_ready_o   | in_word_i  (func, sample, start_req)
// output   | out_valid_o / out_ready_i | out_word_o (level, recon, oor, flat)
// config   | cfg_we_i                  | cfg_data_i (num_levels)
//
// Observe words update the tracked range and give no result.
// A quantize word inside the range passes the command slot into the back engine,
// which runs two 27-step restoring divides at one quotient bit per cycle with one
// setup step between; out_valid_o rises when the second divide ends.
// Flat or out-of-range words skip the divides: out_valid_o rises once the back engine takes them from the slot.
// A one-entry command slot parts front and back; each stalls on its own.
// Reset clears the range (min = max = 0, no range) and num_levels to 8.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module min_max_uniform_quantizer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mmuq_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mmuq_pkg::out_word_t  out_word_o,
  input  logic                 cfg_we_i,
  input  logic [8:0]           cfg_data_i
);
  import mmuq_pkg::*;

  localparam int unsigned LW = LevelW;
  localparam int unsigned MaxL1 = 32'(MaxLevels) - 32'd1;

  logic [CfgW-1:0] lv_q;
  logic [LW-1:0]   l1;
  logic [CfgW-1:0] lv_eff;
  logic            cv, cr;
  logic [1:0]      ccls;
  logic [SampleW:0] cd, cw;
  logic signed [SampleW-1:0] cmn, cmx, rc;
  logic [LW-1:0]   cl1, lvl;
  logic            oor, flt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= LevelsReset;
    end else if (cfg_we_i) begin
      lv_q <= cfg_data_i;
    end
  end

  // Clamp to [2, MaxLevels]
  always_comb begin
    lv_eff = lv_q;
    if (lv_q < CfgW'(2)) lv_eff = CfgW'(2);
    if (lv_q > MaxLevels) lv_eff = MaxLevels;
    l1 = LW'(lv_eff - CfgW'(1));
  end

  mmuq_front #(.SW(SampleW), .LW(LW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .func_i(in_word_i.func), .sample_i(in_word_i.sample),
    .start_req_i(in_word_i.start_req), .l1_i(l1),
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_cls_o(ccls), .cmd_d_o(cd),
    .cmd_w_o(cw), .cmd_min_o(cmn), .cmd_max_o(cmx), .cmd_l1_o(cl1)
  );

  mmuq_back #(.SW(SampleW), .LW(LW)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_ready_o(cr), .cmd_cls_i(ccls),
    .cmd_d_i(cd), .cmd_w_i(cw), .cmd_min_i(cmn), .cmd_max_i(cmx),
    .cmd_l1_i(cl1), .out_valid_o, .out_ready_i, .level_o(lvl), .recon_o(rc),
    .oor_o(oor), .flat_o(flt)
  );

  assign out_word_o = '{level: lvl, recon_value: rc, out_of_range: oor, flat: flt};

  // Assertions
  `ASSERT_RST(a_flat_level0, clk_i, rst_ni, out_valid_o && flt |-> lvl == '0, "flat, level")
  `ASSERT_RST(a_flat_no_oor, clk_i, rst_ni, out_valid_o |-> !(flt && oor), "flat and oor")
  `ASSERT_RST(a_level_cap, clk_i, rst_ni, out_valid_o |-> 32'(lvl) <= MaxL1, "level cap")

endmodule

>>> hdl/mmuq_front.sv
// ---------------------------------------------------------------------------
// mmuq_front: range tracker and classifier
// Updates min/max on observe words; classifies quantize words into a command.
// ---------------------------------------------------------------------------
module mmuq_front #(
  parameter int unsigned SW = 16,
  parameter int unsigned LW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic signed [SW-1:0]     sample_i,
  input  logic                     start_req_i,
  input  logic [LW-1:0]            l1_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output logic [1:0]               cmd_cls_o,
  output logic [SW:0]              cmd_d_o,
  output logic [SW:0]              cmd_w_o,
  output logic signed [SW-1:0]     cmd_min_o,
  output logic signed [SW-1:0]     cmd_max_o,
  output logic [LW-1:0]            cmd_l1_o
);
  import mmuq_pkg::*;

  logic signed [SW-1:0] min_q, max_q;
  logic                 rv_q;
  logic                 cv_q;
  cls_e                 cls_q, cls_d;
  logic [SW:0]          d_q, w_q;
  logic signed [SW-1:0] mn_q, mx_q;
  logic [LW-1:0]        l1_q;
  logic                 acc;

  // Slot frees when the back engine takes it
  assign in_ready_o = !cv_q || cmd_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    if (!rv_q || (max_q == min_q)) begin
      cls_d = CLS_FLAT;
    end else if (sample_i < min_q) begin
      cls_d = CLS_BELOW;
    end else if (sample_i > max_q) begin
      cls_d = CLS_ABOVE;
    end else begin
      cls_d = CLS_INNER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      rv_q  <= 1'b0;
      cv_q  <= 1'b0;
      cls_q <= CLS_FLAT;
    end else begin
      if (acc && func_i == FuncQuantize) begin
        cv_q <= 1'b1;
      end else if (cmd_ready_i) begin
        cv_q <= 1'b0;
      end
      if (acc) begin
        if (func_i == FuncObserve) begin
          rv_q <= 1'b1;
          if (start_req_i || !rv_q) begin
            min_q <= sample_i;
            max_q <= sample_i;
          end else begin
            if (sample_i < min_q) min_q <= sample_i;
            if (sample_i > max_q) max_q <= sample_i;
          end
        end else begin
          cls_q <= cls_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && func_i == FuncQuantize) begin
      d_q  <= {sample_i[SW-1], sample_i} - {min_q[SW-1], min_q};
      w_q  <= {max_q[SW-1], max_q} - {min_q[SW-1], min_q};
      mn_q <= min_q;
      mx_q <= max_q;
      l1_q <= l1_i;
    end
  end

  assign cmd_valid_o = cv_q;
  assign cmd_cls_o   = cls_q;
  assign cmd_d_o     = d_q;
  assign cmd_w_o     = w_q;
  assign cmd_min_o   = mn_q;
  assign cmd_max_o   = mx_q;
  assign cmd_l1_o    = l1_q;

endmodule

>>> hdl/mmuq_back.sv
// ---------------------------------------------------------------------------
// mmuq_back: level and reconstruction engine
// Two restoring divisions for in-range samples, one quotient bit per cycle, then an output reg.
// ---------------------------------------------------------------------------
module mmuq_back #(
  parameter int unsigned SW = 16,
  parameter int unsigned LW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  logic [1:0]               cmd_cls_i,
  input  logic [SW:0]              cmd_d_i,
  input  logic [SW:0]              cmd_w_i,
  input  logic signed [SW-1:0]     cmd_min_i,
  input  logic signed [SW-1:0]     cmd_max_i,
  input  logic [LW-1:0]            cmd_l1_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [LW-1:0]            level_o,
  output logic signed [SW-1:0]     recon_o,
  output logic                     oor_o,
  output logic                     flat_o
);
  import mmuq_pkg::*;

  // Numerators fit in NW bits: 2*W*L1 + W
  localparam int unsigned NW = SW + LW + 3;
  localparam int unsigned CW = $clog2(NW + 1);

  bk_state_e st_q, st_d;
  logic [NW-1:0] num_q, num_d;   // dividend bits shift out, quotient bits shift in
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW:0]   w_q;
  logic [LW-1:0] l1_q, lvl_q, lvl_d;
  logic signed [SW-1:0] mn_q, rc_q, rc_d;
  logic          oor_q, flat_q, oor_d, flat_d;
  logic          ov_q, ov_d;
  logic [NW-1:0] trial;
  logic          fit;
  logic [NW-1:0] prod_dl;
  logic [NW-1:0] prod_wl;

  assign trial = {rem_q[NW-2:0], num_q[NW-1]};
  assign fit   = trial >= den_q;
  assign prod_dl = NW'(cmd_d_i) * NW'(cmd_l1_i);
  assign prod_wl = NW'(w_q) * NW'(lvl_q);

  assign cmd_ready_o = (st_q == BK_IDLE) && !ov_q;

  always_comb begin
    st_d   = st_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    lvl_d  = lvl_q;
    rc_d   = rc_q;
    oor_d  = oor_q;
    flat_d = flat_q;
    ov_d   = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i && !ov_q) begin
          lvl_d  = '0;
          rc_d   = cmd_min_i;
          oor_d  = 1'b0;
          flat_d = 1'b0;
          case (cls_e'(cmd_cls_i))
            CLS_FLAT:  begin flat_d = 1'b1; ov_d = 1'b1; end
            CLS_BELOW: begin oor_d = 1'b1; ov_d = 1'b1; end
            CLS_ABOVE: begin
              oor_d = 1'b1; lvl_d = cmd_l1_i; rc_d = cmd_max_i; ov_d = 1'b1;
            end
            default: begin
              num_d = (prod_dl << 1) + NW'(cmd_w_i) - NW'(1);
              den_d = NW'(cmd_w_i) << 1;
              rem_d = '0;
              cnt_d = CW'(NW);
              st_d  = BK_DIV1;
            end
          endcase
        end
      end
      BK_DIV1, BK_DIV2: begin
        rem_d = fit ? trial - den_q : trial;
        num_d = {num_q[NW-2:0], fit};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          if (st_q == BK_DIV1) begin
            lvl_d = num_d[LW-1:0];
            st_d  = BK_OUT;
          end else begin
            rc_d  = mn_q + SW'(num_d);
            ov_d  = 1'b1;
            st_d  = BK_IDLE;
          end
        end
      end
      BK_OUT: begin
        // Set up reconstruction divide
        num_d = (prod_wl << 1) + NW'(l1_q);
        den_d = NW'(l1_q) << 1;
        rem_d = '0;
        cnt_d = CW'(NW);
        st_d  = BK_DIV2;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    cnt_q  <= cnt_d;
    lvl_q  <= lvl_d;
    rc_q   <= rc_d;
    oor_q  <= oor_d;
    flat_q <= flat_d;
    if (st_q == BK_IDLE && cmd_valid_i && !ov_q) begin
      w_q  <= cmd_w_i;
      l1_q <= cmd_l1_i;
      mn_q <= cmd_min_i;
    end
  end

  assign out_valid_o = ov_q;
  assign level_o     = lvl_q;
  assign recon_o     = rc_q;
  assign oor_o       = oor_q;
  assign flat_o      = flat_q;

endmodule
